// ===== hw/rtl/mbps_pkg.sv =====
`default_nettype none

package mbps_pkg;

   // Pattern positions held in the cell row.
   localparam int PATTERN_MAX = 64;
   localparam int IDX_W       = $clog2(PATTERN_MAX);
   localparam int LEN_W       = 7;
   localparam int OFF_W       = 16;
   localparam int ADDR_W      = 48;
   localparam int BYTE_W      = 8;
   localparam int ACT_W       = 2;
   localparam int CSR_IDX_W   = 2;

   // Item actions.
   localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_SCAN    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_OFFSET   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE    = 2'd2;

   localparam logic [LEN_W-1:0] LEN_RESET = 7'd1;

   // Controls broadcast along the cell row.
   typedef struct packed {
      logic              shift;
      logic [BYTE_W-1:0] load_byte;
      logic              load_wild;
   } cell_ctl_type;

   // A window of bytes, entry 0 is the newest byte.
   typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] window_type;

   // Item state between the compare stage and the result stage.
   typedef struct packed {
      logic                   is_scan;
      logic                   is_restart;
      logic                   last;
      logic                   full;
      logic [ADDR_W-1:0]      start;
      logic [PATTERN_MAX-1:0] eq;
   } stage_type;

endpackage

`default_nettype wire

// ===== hw/rtl/masked_byte_pattern_scanner_unit.sv =====
`default_nettype none

// A scan item that causes a result passes through the result stage register and then the
// output register before reaching rsp_valid; the window shifts one byte per scan item.
// Throughput: one item per cycle, except while a result waits on a busy output.
// Reset clears the handshake, position and done state and sets the registers to their
// reset values; pattern entries are undefined until loaded, and no clearing pass runs.
module masked_byte_pattern_scanner_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [mbps_pkg::ACT_W-1:0]          req_action,
   input  wire logic [mbps_pkg::IDX_W-1:0]          req_pattern_index,
   input  wire logic [mbps_pkg::BYTE_W-1:0]         req_pattern_byte,
   input  wire logic                                req_pattern_wild,
   input  wire logic [mbps_pkg::BYTE_W-1:0]         req_data_byte,
   input  wire logic                                req_last,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_found,
   output logic      [mbps_pkg::ADDR_W-1:0]         rsp_match_address,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mbps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mbps_pkg::ADDR_W-1:0]         csr_data
);

   localparam int N = mbps_pkg::PATTERN_MAX;

   // Configuration registers.
   logic [mbps_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [mbps_pkg::OFF_W-1:0]  off_ff, off_in;
   logic [mbps_pkg::ADDR_W-1:0] base_ff, base_in;
   logic [mbps_pkg::LEN_W-1:0]  eff_len;

   // Front stage.
   logic                        req_fire;
   logic                        is_load;
   logic                        is_scan;
   logic                        is_restart;
   logic [mbps_pkg::ADDR_W-1:0] pos_ff, pos_in;
   logic [mbps_pkg::ADDR_W-1:0] pos_next;

   mbps_pkg::cell_ctl_type      cell_ctl;
   logic [N-1:0]                load_en;
   mbps_pkg::window_type        win_q;
   mbps_pkg::window_type        new_window;
   mbps_pkg::window_type        lanes;
   logic [N-1:0]                cell_eq;
   logic [N-1:0]                eq_masked;

   // Result stage.
   logic                        s1_valid_ff, s1_valid_in;
   mbps_pkg::stage_type         s1_ff, s1_in;
   logic                        done_ff, done_in;
   logic                        hit;
   logic                        produce;
   logic                        s1_move;
   logic                        out_free;
   logic [mbps_pkg::ADDR_W-1:0] offset_ext;
   logic [mbps_pkg::ADDR_W-1:0] address;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [mbps_pkg::ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   // Configuration port.
   assign csr_ready = 1'b1;

   always_comb begin
      len_in  = len_ff;
      off_in  = off_ff;
      base_in = base_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mbps_pkg::CSR_PATTERN_LENGTH: len_in  = csr_data[mbps_pkg::LEN_W-1:0];
            mbps_pkg::CSR_MATCH_OFFSET:   off_in  = csr_data[mbps_pkg::OFF_W-1:0];
            mbps_pkg::CSR_REGION_BASE:    base_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (len_ff == '0) begin
         eff_len = mbps_pkg::LEN_W'(1);
      end else if (len_ff > mbps_pkg::LEN_W'(N)) begin
         eff_len = mbps_pkg::LEN_W'(N);
      end else begin
         eff_len = len_ff;
      end
   end

   // Item decode and cell row controls.
   assign req_fire   = req_valid & req_ready;
   assign is_load    = (req_action == mbps_pkg::ACT_LOAD);
   assign is_scan    = (req_action == mbps_pkg::ACT_SCAN);
   assign is_restart = (req_action == mbps_pkg::ACT_RESTART);

   assign cell_ctl.shift     = req_fire & is_scan;
   assign cell_ctl.load_byte = req_pattern_byte;
   assign cell_ctl.load_wild = req_pattern_wild;

   genvar gi;
   generate
      for (gi = 0; gi < N; gi++) begin : g_row
         if (gi == 0) begin : g_head
            assign new_window[gi] = req_data_byte;
         end else begin : g_link
            assign new_window[gi] = win_q[gi-1];
         end

         assign load_en[gi] = req_fire & is_load &
                              (req_pattern_index == mbps_pkg::IDX_W'(gi));

         mbps_cell u_cell (
            .clock       (clock),
            .ctl         (cell_ctl),
            .load_en     (load_en[gi]),
            .prev_byte   (new_window[gi]),
            .lane_byte   (lanes[gi]),
            .window_byte (win_q[gi]),
            .eq          (cell_eq[gi])
         );

         // Positions beyond the pattern length always agree.
         assign eq_masked[gi] = cell_eq[gi] | (mbps_pkg::LEN_W'(gi) >= eff_len);
      end
   endgenerate

   mbps_align u_align (
      .new_window (new_window),
      .eff_len    (eff_len),
      .lanes      (lanes)
   );

   // Byte count since the last restart. Counting on after a result is harmless:
   // only a restart re-opens the region, and it clears the count.
   assign pos_next = pos_ff + mbps_pkg::ADDR_W'(1);

   always_comb begin
      pos_in = pos_ff;
      if (req_fire && is_restart) begin
         pos_in = '0;
      end else if (req_fire && is_scan) begin
         pos_in = pos_next;
      end
   end

   always_comb begin
      s1_in.is_scan    = is_scan;
      s1_in.is_restart = is_restart;
      s1_in.last       = req_last;
      s1_in.full       = (pos_next >= mbps_pkg::ADDR_W'(eff_len));
      s1_in.start      = pos_next - mbps_pkg::ADDR_W'(eff_len);
      s1_in.eq         = eq_masked;
   end

   // Result stage. The done flag is kept here, in item order, so a scan item
   // that entered behind a finished region is simply dropped.
   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign hit        = s1_ff.full & (&s1_ff.eq);
   assign produce    = s1_valid_ff & s1_ff.is_scan & ~done_ff & (hit | s1_ff.last);
   assign s1_move    = s1_valid_ff & (~produce | out_free);
   assign req_ready  = ~s1_valid_ff | s1_move;

   assign offset_ext = {{(mbps_pkg::ADDR_W-mbps_pkg::OFF_W){off_ff[mbps_pkg::OFF_W-1]}},
                        off_ff};
   assign address    = base_ff + s1_ff.start + offset_ext;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      done_in = done_ff;
      if (s1_move && s1_ff.is_restart) begin
         done_in = 1'b0;
      end else if (s1_move && produce) begin
         done_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_addr_in  = rsp_addr_ff;
      if (s1_move && produce) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = hit;
         rsp_addr_in  = hit ? address : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= mbps_pkg::LEN_RESET;
         off_ff       <= '0;
         base_ff      <= '0;
         pos_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         off_ff       <= off_in;
         base_ff      <= base_in;
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
      rsp_found_ff <= rsp_found_in;
      rsp_addr_ff  <= rsp_addr_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_match_address = rsp_addr_ff;

   // A region that ended without a match reports a zero address.
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_match_address == '0))
      else $error("not-found result carries a nonzero address");

   // Once a result leaves the result stage, the region is closed.
   a_done_after_result: assert property (@(posedge clock) disable iff (reset)
      (s1_move && produce) |=> done_ff)
      else $error("done flag not set after a result");

   // A restart re-opens the region.
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_move && s1_ff.is_restart) |=> !done_ff)
      else $error("done flag survived a restart");

   // An accepted item always lands in the result stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted item lost before the result stage");

endmodule

`default_nettype wire

// ===== hw/rtl/mbps_cell.sv =====
`default_nettype none

module mbps_cell (
   input  wire logic                          clock,
   input  wire mbps_pkg::cell_ctl_type        ctl,
   input  wire logic                          load_en,
   input  wire logic [mbps_pkg::BYTE_W-1:0]   prev_byte,
   input  wire logic [mbps_pkg::BYTE_W-1:0]   lane_byte,
   output logic      [mbps_pkg::BYTE_W-1:0]   window_byte,
   output logic                               eq
);

   logic [mbps_pkg::BYTE_W-1:0] win_ff;
   logic [mbps_pkg::BYTE_W-1:0] win_in;
   logic [mbps_pkg::BYTE_W-1:0] pat_ff;
   logic [mbps_pkg::BYTE_W-1:0] pat_in;
   logic                        wild_ff;
   logic                        wild_in;

   always_comb begin
      win_in  = ctl.shift ? prev_byte : win_ff;
      pat_in  = load_en ? ctl.load_byte : pat_ff;
      wild_in = load_en ? ctl.load_wild : wild_ff;
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      pat_ff  <= pat_in;
      wild_ff <= wild_in;
   end

   assign window_byte = win_ff;
   assign eq          = wild_ff | (pat_ff == lane_byte);

endmodule

`default_nettype wire

// ===== hw/rtl/mbps_align.sv =====
`default_nettype none

module mbps_align (
   input  wire mbps_pkg::window_type             new_window,
   input  wire logic [mbps_pkg::LEN_W-1:0]       eff_len,
   output mbps_pkg::window_type                  lanes
);

   mbps_pkg::window_type              rev;
   logic [mbps_pkg::IDX_W-1:0]        gap;

   // Lane i must see the byte that arrived eff_len-1-i items ago. Reversing
   // the window puts the newest byte on top, and a right shift by the unused
   // depth brings the oldest byte of the active window down to lane 0.
   always_comb begin
      for (int k = 0; k < mbps_pkg::PATTERN_MAX; k++) begin
         rev[k] = new_window[mbps_pkg::PATTERN_MAX-1-k];
      end
      gap   = mbps_pkg::IDX_W'(mbps_pkg::LEN_W'(mbps_pkg::PATTERN_MAX) - eff_len);
      lanes = rev >> {gap, 3'b000};
   end

endmodule

`default_nettype wire

// ===== dv/masked_byte_pattern_scanner_unit_tb.sv =====
`default_nettype none

module masked_byte_pattern_scanner_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [mbps_pkg::ACT_W-1:0]     ACT_UNUSED    = 2'd3;
   localparam logic [mbps_pkg::CSR_IDX_W-1:0] CSR_UNUSED    = 2'd3;
   localparam int                             SETTLE_CYCLES = 6;
   localparam int                             LONG_HOLD     = 300;
   localparam int                             STALL_LIMIT   = 3000;
   localparam int                             RANDOM_ITEMS  = 200;

   typedef struct packed {
      logic                        found;
      logic [mbps_pkg::ADDR_W-1:0] address;
   } scan_hit_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [mbps_pkg::ACT_W-1:0]     req_action;
   logic [mbps_pkg::IDX_W-1:0]     req_pattern_index;
   logic [mbps_pkg::BYTE_W-1:0]    req_pattern_byte;
   logic                           req_pattern_wild;
   logic [mbps_pkg::BYTE_W-1:0]    req_data_byte;
   logic                           req_last;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_found;
   logic [mbps_pkg::ADDR_W-1:0]    rsp_match_address;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [mbps_pkg::CSR_IDX_W-1:0] csr_index;
   logic [mbps_pkg::ADDR_W-1:0]    csr_data;

   // Predicted block state.
   logic [mbps_pkg::BYTE_W-1:0] win_bytes  [mbps_pkg::PATTERN_MAX];
   logic [mbps_pkg::BYTE_W-1:0] pat_store  [mbps_pkg::PATTERN_MAX];
   logic                        wild_marks [mbps_pkg::PATTERN_MAX];
   logic [mbps_pkg::ADDR_W-1:0] scan_pos;
   logic                        scan_over;
   logic [mbps_pkg::LEN_W-1:0]  cfg_len;
   logic [mbps_pkg::OFF_W-1:0]  cfg_offset;
   logic [mbps_pkg::ADDR_W-1:0] cfg_base;

   scan_hit_type pending_hits [$];

   int  mismatches      = 0;
   int  items_sent      = 0;
   int  idle_cycles     = 0;
   int  rsp_gap_left    = 0;
   int  holds_requested = 0;
   int  holds_granted   = 0;
   bit  idle_on         = 1'b1;
   bit  req_held        = 1'b0;

   masked_byte_pattern_scanner_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_pattern_index (req_pattern_index),
      .req_pattern_byte  (req_pattern_byte),
      .req_pattern_wild  (req_pattern_wild),
      .req_data_byte     (req_data_byte),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_match_address (rsp_match_address),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 93) return $urandom_range(3, 6);
      return $urandom_range(15, 40);
   endfunction

   function automatic int scan_width();
      if (cfg_len == 0) return 1;
      if (int'(cfg_len) > mbps_pkg::PATTERN_MAX) return mbps_pkg::PATTERN_MAX;
      return int'(cfg_len);
   endfunction

   // Applies one accepted item to the predicted state and queues its result, if any.
   function automatic void scan_predict(logic [mbps_pkg::ACT_W-1:0] act,
                                        logic [mbps_pkg::IDX_W-1:0] idx,
                                        logic [mbps_pkg::BYTE_W-1:0] pbyte, logic pwild,
                                        logic [mbps_pkg::BYTE_W-1:0] dbyte, logic lst);
      int           width;
      int           i;
      bit           hit;
      scan_hit_type res;
      if (act == mbps_pkg::ACT_LOAD) begin
         pat_store[idx]  = pbyte;
         wild_marks[idx] = pwild;
      end else if (act == mbps_pkg::ACT_RESTART) begin
         scan_pos  = '0;
         scan_over = 1'b0;
      end else if (act == mbps_pkg::ACT_SCAN && !scan_over) begin
         width = scan_width();
         for (i = mbps_pkg::PATTERN_MAX - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
         win_bytes[0] = dbyte;
         scan_pos = scan_pos + 1'b1;
         hit = (scan_pos >= mbps_pkg::ADDR_W'(width));
         // Pattern entry 0 lines up with the oldest byte of the window.
         for (i = 0; i < width; i++) begin
            if (!wild_marks[i] && pat_store[i] != win_bytes[width-1-i]) hit = 1'b0;
         end
         if (hit) begin
            res.found   = 1'b1;
            res.address = cfg_base + (scan_pos - mbps_pkg::ADDR_W'(width))
                        + {{(mbps_pkg::ADDR_W-mbps_pkg::OFF_W){cfg_offset[mbps_pkg::OFF_W-1]}},
                           cfg_offset};
            pending_hits.push_back(res);
            scan_over = 1'b1;
         end else if (lst) begin
            res.found   = 1'b0;
            res.address = '0;
            pending_hits.push_back(res);
            scan_over = 1'b1;
         end
      end
   endfunction

   task automatic drop_req();
      if (req_held) begin
         req_valid <= 1'b0;
         req_held  = 1'b0;
      end
   endtask

   task automatic send_item(logic [mbps_pkg::ACT_W-1:0] act, logic [mbps_pkg::IDX_W-1:0] idx,
                            logic [mbps_pkg::BYTE_W-1:0] pbyte, logic pwild,
                            logic [mbps_pkg::BYTE_W-1:0] dbyte, logic lst);
      int gap;
      gap = (idle_on && $urandom_range(99) < 30) ? pick_gap() : 0;
      if (gap > 0) begin
         drop_req();
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_pattern_index <= idx;
      req_pattern_byte  <= pbyte;
      req_pattern_wild  <= pwild;
      req_data_byte     <= dbyte;
      req_last          <= lst;
      req_held = 1'b1;
      do @(posedge clock); while (!req_ready);
      scan_predict(act, idx, pbyte, pwild, dbyte, lst);
      items_sent++;
   endtask

   task automatic load_entry(logic [mbps_pkg::IDX_W-1:0] idx,
                             logic [mbps_pkg::BYTE_W-1:0] pbyte, logic pwild);
      send_item(mbps_pkg::ACT_LOAD, idx, pbyte, pwild, mbps_pkg::BYTE_W'($urandom),
                1'($urandom));
   endtask

   task automatic scan_byte(logic [mbps_pkg::BYTE_W-1:0] dbyte, logic lst);
      send_item(mbps_pkg::ACT_SCAN, mbps_pkg::IDX_W'($urandom), mbps_pkg::BYTE_W'($urandom),
                1'($urandom), dbyte, lst);
   endtask

   task automatic restart_scan();
      send_item(mbps_pkg::ACT_RESTART, mbps_pkg::IDX_W'($urandom),
                mbps_pkg::BYTE_W'($urandom), 1'($urandom),
                mbps_pkg::BYTE_W'($urandom), 1'($urandom));
   endtask

   // Registers change only once the block has drained.
   task automatic wait_quiet();
      drop_req();
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [mbps_pkg::CSR_IDX_W-1:0] idx,
                            logic [mbps_pkg::ADDR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         mbps_pkg::CSR_PATTERN_LENGTH: cfg_len    = value[mbps_pkg::LEN_W-1:0];
         mbps_pkg::CSR_MATCH_OFFSET:   cfg_offset = value[mbps_pkg::OFF_W-1:0];
         mbps_pkg::CSR_REGION_BASE:    cfg_base   = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Upper data bits of the narrow registers carry noise; the block keeps only the low bits.
   task automatic set_config(logic [mbps_pkg::LEN_W-1:0] plen, logic [mbps_pkg::OFF_W-1:0] off,
                             logic [mbps_pkg::ADDR_W-1:0] base);
      logic [mbps_pkg::ADDR_W-1:0] d;
      d = {16'($urandom), 32'($urandom)};
      d[mbps_pkg::LEN_W-1:0] = plen;
      csr_write(mbps_pkg::CSR_PATTERN_LENGTH, d);
      d = {16'($urandom), 32'($urandom)};
      d[mbps_pkg::OFF_W-1:0] = off;
      csr_write(mbps_pkg::CSR_MATCH_OFFSET, d);
      csr_write(mbps_pkg::CSR_REGION_BASE, base);
   endtask

   task automatic test_directed_cases();
      // Reset length of one: a single-byte pattern.
      load_entry(6'd0, 8'hFF, 1'b0);
      scan_byte(8'h00, 1'b0);
      scan_byte(8'hFF, 1'b0);
      scan_byte(8'hFF, 1'b1);
      send_item(ACT_UNUSED, 6'h3F, 8'hFF, 1'b1, 8'hFF, 1'b1);
      restart_scan();
      scan_byte(8'h00, 1'b1);

      wait_quiet();
      set_config(7'd4, 16'h8000, 48'h0);
      csr_write(CSR_UNUSED, {16'($urandom), 32'($urandom)});
      load_entry(6'd0, 8'h00, 1'b0);
      load_entry(6'd1, 8'hA5, 1'b1);
      load_entry(6'd2, 8'h5A, 1'b0);
      load_entry(6'd3, 8'hFF, 1'b0);
      load_entry(6'h3F, 8'h3C, 1'b1);
      // Match that lands on the last byte, address wraps below zero.
      restart_scan();
      scan_byte(8'h00, 1'b0);
      scan_byte(8'h77, 1'b0);
      scan_byte(8'h5A, 1'b0);
      scan_byte(8'hFF, 1'b1);
      // Region shorter than the pattern.
      restart_scan();
      scan_byte(8'h00, 1'b0);
      scan_byte(8'h11, 1'b1);
      // The kept window would match, but it is not full again after the restart.
      restart_scan();
      scan_byte(8'h5A, 1'b0);
      scan_byte(8'hFF, 1'b0);
      scan_byte(8'h01, 1'b1);

      wait_quiet();
      set_config(7'd0, 16'h7FFF, 48'hFFFF_FFFF_FFFF);
      restart_scan();
      scan_byte(8'h00, 1'b0);
   endtask

   task automatic test_full_window();
      logic [mbps_pkg::BYTE_W-1:0] bytes_buf [0:79];
      int                          k;
      wait_quiet();
      set_config(7'h7F, 16'($urandom), {16'($urandom), 32'($urandom)});
      for (k = 0; k < mbps_pkg::PATTERN_MAX; k++) begin
         load_entry(mbps_pkg::IDX_W'(k), mbps_pkg::BYTE_W'($urandom),
                    $urandom_range(99) < 30);
      end
      restart_scan();
      for (k = 0; k < 72; k++) bytes_buf[k] = mbps_pkg::BYTE_W'($urandom);
      for (k = 0; k < mbps_pkg::PATTERN_MAX; k++) begin
         if (!wild_marks[k]) bytes_buf[6+k] = pat_store[k];
      end
      for (k = 0; k < 72; k++) scan_byte(bytes_buf[k], k == 71);
      restart_scan();
      for (k = 0; k < 30; k++) scan_byte(mbps_pkg::BYTE_W'($urandom), k == 29);
   endtask

   // Every scan byte matches, so each pair of items makes a result while the receiver is held.
   task automatic test_backpressure();
      wait_quiet();
      set_config(7'd1, 16'($urandom), {16'($urandom), 32'($urandom)});
      load_entry(6'd0, 8'hFF, 1'b1);
      idle_on = 1'b0;
      holds_requested++;
      repeat (24) begin
         restart_scan();
         scan_byte(mbps_pkg::BYTE_W'($urandom), 1'b0);
      end
      idle_on = 1'b1;
   endtask

   task automatic test_random_regions();
      logic [mbps_pkg::BYTE_W-1:0] bytes_buf [0:127];
      logic [mbps_pkg::LEN_W-1:0]  len_cfg;
      logic [mbps_pkg::OFF_W-1:0]  off_cfg;
      logic [mbps_pkg::ADDR_W-1:0] base_cfg;
      int                          start_count;
      int                          width;
      int                          span;
      int                          p;
      int                          r;
      int                          alpha;
      int                          n_regions;
      int                          n;
      int                          k;
      bit                          broken;
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         wait_quiet();
         r = $urandom_range(99);
         if (r < 80) len_cfg = mbps_pkg::LEN_W'($urandom_range(1, 8));
         else if (r < 95) len_cfg = mbps_pkg::LEN_W'($urandom_range(9, 24));
         else len_cfg = mbps_pkg::LEN_W'(mbps_pkg::PATTERN_MAX);
         r = $urandom_range(99);
         if (r < 10) off_cfg = 16'h8000;
         else if (r < 20) off_cfg = 16'h7FFF;
         else if (r < 25) off_cfg = 16'h0000;
         else off_cfg = mbps_pkg::OFF_W'($urandom);
         if ($urandom_range(99) < 15) base_cfg = {40'hFF_FFFF_FFFF, 8'($urandom)};
         else base_cfg = {16'($urandom), 32'($urandom)};
         set_config(len_cfg, off_cfg, base_cfg);
         width = int'(len_cfg);
         // A small alphabet makes near misses and overlapping partial matches common.
         alpha = ($urandom_range(99) < 30) ? 3 : 255;
         idle_on = ($urandom_range(3) != 0);
         for (k = 0; k < width; k++) begin
            load_entry(mbps_pkg::IDX_W'(k), mbps_pkg::BYTE_W'($urandom_range(alpha)),
                       $urandom_range(99) < 25);
         end
         n_regions = $urandom_range(3, 8);
         for (n = 0; n < n_regions; n++) begin
            if ($urandom_range(9) != 0) restart_scan();
            span = width + $urandom_range(0, 12);
            if (width > 1 && $urandom_range(9) == 0) span = $urandom_range(1, width - 1);
            for (k = 0; k < span; k++) bytes_buf[k] = mbps_pkg::BYTE_W'($urandom_range(alpha));
            if (span >= width && $urandom_range(99) < 65) begin
               p = $urandom_range(0, span - width);
               for (k = 0; k < width; k++) begin
                  if (!wild_marks[k]) bytes_buf[p+k] = pat_store[k];
               end
            end
            broken = ($urandom_range(99) < 8);
            for (k = 0; k < span; k++) begin
               r = $urandom_range(99);
               if (r < 3) begin
                  send_item(ACT_UNUSED, mbps_pkg::IDX_W'($urandom),
                            mbps_pkg::BYTE_W'($urandom), 1'($urandom),
                            mbps_pkg::BYTE_W'($urandom), 1'($urandom));
               end else if (r < 6) begin
                  load_entry(mbps_pkg::IDX_W'($urandom),
                             mbps_pkg::BYTE_W'($urandom_range(alpha)), 1'($urandom));
               end
               scan_byte(bytes_buf[k], (k == span - 1) && !broken);
            end
            // Bytes after the region has its result are dropped by the block.
            if ($urandom_range(99) < 20) begin
               repeat ($urandom_range(1, 3)) begin
                  scan_byte(mbps_pkg::BYTE_W'($urandom), 1'($urandom));
               end
            end
         end
      end
      idle_on = 1'b1;
   endtask

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endtask

   // Receiver: random gaps, plus one long hold when a test asks for it.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready    <= 1'b0;
         rsp_gap_left <= 0;
      end else if (holds_granted != holds_requested) begin
         holds_granted <= holds_requested;
         rsp_ready     <= 1'b0;
         rsp_gap_left  <= LONG_HOLD;
      end else if (rsp_gap_left > 0) begin
         rsp_ready    <= 1'b0;
         rsp_gap_left <= rsp_gap_left - 1;
      end else if (!idle_on || $urandom_range(99) < 75) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready    <= 1'b0;
         rsp_gap_left <= pick_gap() - 1;
      end
   end

   always @(posedge clock) begin : check_results
      scan_hit_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_hits.size() == 0) begin
            report_mismatch($sformatf("unexpected result: found=%0d address=%h",
                                      rsp_found, rsp_match_address));
         end else begin
            want = pending_hits.pop_front();
            if (rsp_found !== want.found || rsp_match_address !== want.address) begin
               report_mismatch($sformatf(
                  "result mismatch: expected found=%0d address=%h, got found=%0d address=%h",
                  want.found, want.address, rsp_found, rsp_match_address));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int k;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_action        = mbps_pkg::ACT_LOAD;
      req_pattern_index = '0;
      req_pattern_byte  = '0;
      req_pattern_wild  = 1'b0;
      req_data_byte     = '0;
      req_last          = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = mbps_pkg::CSR_PATTERN_LENGTH;
      csr_data          = '0;
      for (k = 0; k < mbps_pkg::PATTERN_MAX; k++) begin
         win_bytes[k]  = '0;
         pat_store[k]  = '0;
         wild_marks[k] = 1'b0;
      end
      scan_pos   = '0;
      scan_over  = 1'b0;
      cfg_len    = mbps_pkg::LEN_RESET;
      cfg_offset = '0;
      cfg_base   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_full_window();
      test_backpressure();
      test_random_regions();

      wait_quiet();
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
